@@ hdl/eyxz_pkg.sv @@
package eyxz_pkg;

    localparam int ANGLE_BITS_DEF     = 16;
    localparam int TRIG_FRAC_BITS_DEF = 14;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 240;

    localparam logic [31:0] POLY_A  = 32'd1686629713;
    localparam logic [31:0] POLY_B  = 32'd688904866;
    localparam logic [31:0] POLY_C  = 32'd76016977;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;

endpackage

@@ hdl/eyxz_sincos.sv @@
// Pipelined sine/cosine of one binary angle: quarter-wave polynomial in Q30,
// at most one multiply per stage; a new angle may enter each cycle while en is high.
module eyxz_sincos
    import eyxz_pkg::*;
#(
    parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             en,
    input  logic [15:0]                      angle,
    output logic signed [TRIG_FRAC_BITS+1:0] sin_q,
    output logic signed [TRIG_FRAC_BITS+1:0] cos_q
);

    localparam int AB = ANGLE_BITS;
    localparam int SH = 30 - TRIG_FRAC_BITS;
    localparam int TW = TRIG_FRAC_BITS + 2;

    logic [AB-1:0] phase;
    logic [AB-1:0] phase_c;
    logic [1:0]    quad_s_reg [0:4];
    logic [1:0]    quad_c_reg [0:4];
    logic [30:0]   xs_reg [0:3];
    logic [30:0]   xc_reg [0:3];
    logic [30:0]   x2s_reg [1:2];
    logic [30:0]   x2c_reg [1:2];
    logic [31:0]   ts_reg, tc_reg;
    logic [31:0]   ts2_reg, tc2_reg;
    logic [31:0]   ts3_reg, tc3_reg;
    logic signed [TW-1:0] sin_reg, cos_reg;

    generate
        if (AB >= 16)
        begin : g_up
            assign phase = AB'(angle) << (AB - 16);
        end
        else
        begin : g_dn
            assign phase = angle[15 -: AB];
        end
    endgenerate

    assign phase_c = phase + (AB)'(1 << (AB - 2));

    function automatic logic [30:0] fold(input logic [AB-1:0] p);
        logic [30:0] x;
        x = 31'({p[AB-3:0], {(32-AB){1'b0}}});
        if (p[AB-2])
        begin
            x = Q30_ONE - x;
        end
        return x;
    endfunction

    function automatic logic signed [TW-1:0] fin(input logic [31:0] v, input logic neg);
        logic [32:0] r;
        logic signed [TW-1:0] m;
        r = ({1'b0, v} + (33'd1 << (SH - 1))) >> SH;
        m = TW'(r);
        return neg ? -m : m;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_s_reg[0] <= phase[AB-1 -: 2];
            quad_c_reg[0] <= phase_c[AB-1 -: 2];
            xs_reg[0]     <= fold(phase);
            xc_reg[0]     <= fold(phase_c);
            for (int i = 1; i < 5; i++)
            begin
                quad_s_reg[i] <= quad_s_reg[i-1];
                quad_c_reg[i] <= quad_c_reg[i-1];
            end
            for (int i = 1; i < 4; i++)
            begin
                xs_reg[i] <= xs_reg[i-1];
                xc_reg[i] <= xc_reg[i-1];
            end
            x2s_reg[1] <= 31'((62'(xs_reg[0]) * 62'(xs_reg[0])) >> 30);
            x2c_reg[1] <= 31'((62'(xc_reg[0]) * 62'(xc_reg[0])) >> 30);
            x2s_reg[2] <= x2s_reg[1];
            x2c_reg[2] <= x2c_reg[1];
            ts_reg  <= POLY_B - 32'((64'(POLY_C) * 64'(x2s_reg[1])) >> 30);
            tc_reg  <= POLY_B - 32'((64'(POLY_C) * 64'(x2c_reg[1])) >> 30);
            ts2_reg <= POLY_A - 32'((64'(ts_reg) * 64'(x2s_reg[2])) >> 30);
            tc2_reg <= POLY_A - 32'((64'(tc_reg) * 64'(x2c_reg[2])) >> 30);
            ts3_reg <= 32'((64'(ts2_reg) * 64'(xs_reg[3])) >> 30);
            tc3_reg <= 32'((64'(tc2_reg) * 64'(xc_reg[3])) >> 30);
            sin_reg <= fin(ts3_reg, quad_s_reg[4][1]);
            cos_reg <= fin(tc3_reg, quad_c_reg[4][1]);
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

@@ hdl/euler_yxz_view_matrix_top.sv @@
// Camera view matrix from three Euler angles (Y-X-Z order) and a position.
// Input stream s_axis: tdata carries pitch, yaw, roll (16 bits each) then
// pos_x, pos_y, pos_z (Q16.16). Output stream m_axis: tdata carries the nine
// Q2.14 rotation entries u, v, w then the three saturated Q16.16 translations.
// One transfer in gives one transfer out. m_axis_tvalid is the last of the
// valid bits that shift alongside the data registers. Throughput is one item
// per cycle while the receiver does not stall, set by the
// fully pipelined sine/cosine units and the product stages.
// The whole pipeline advances together; when the receiver stalls with the
// output register full, every stage holds and s_axis_tready falls, so no
// item is lost or repeated. Reset clears all valid bits; data registers are
// not reset.
module euler_yxz_view_matrix_top
    import eyxz_pkg::*;
#(
    parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // pitch_angle, yaw_angle, roll_angle, pos_x, pos_y, pos_z
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // right_x..z, up_x..z, fwd_x..z, trans_u, trans_v, trans_w
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int TW    = TRIG_FRAC_BITS + 2;
    localparam int F     = TRIG_FRAC_BITS;
    localparam int DEPTH = 12;

    logic en;
    logic [DEPTH-1:0] vld_reg;

    assign en            = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    logic signed [TW-1:0] s1, c1, s2, c2, s3, c3;

    eyxz_sincos #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_pitch (
        .clk(clk), .en(en), .angle(s_axis_tdata[15:0]), .sin_q(s2), .cos_q(c2)
    );
    eyxz_sincos #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_yaw (
        .clk(clk), .en(en), .angle(s_axis_tdata[31:16]), .sin_q(s1), .cos_q(c1)
    );
    eyxz_sincos #(.ANGLE_BITS(ANGLE_BITS), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_roll (
        .clk(clk), .en(en), .angle(s_axis_tdata[47:32]), .sin_q(s3), .cos_q(c3)
    );

    // Position rides alongside the trig pipeline (6 stages) and products (3).
    logic [95:0] pos_reg [0:8];

    function automatic logic signed [TW+1:0] tm(input logic signed [TW+1:0] a,
                                                 input logic signed [TW+1:0] b);
        logic signed [2*TW+3:0] p;
        p = (2*TW+4)'(a) * (2*TW+4)'(b) + (2*TW+4)'(1 << (F - 1));
        return (TW+2)'(p >>> F);
    endfunction

    function automatic logic signed [15:0] to14(input logic signed [TW+2:0] v);
        logic signed [TW+17:0] r;
        if (F >= 14)
        begin
            r = ((TW+18)'(v) + (TW+18)'((1 << (F - 14)) >> 1)) >>> (F - 14);
        end
        else
        begin
            r = (TW+18)'(v) <<< (14 - F);
        end
        if (r > 16384)
        begin
            r = (TW+18)'(16384);
        end
        else if (r < -16384)
        begin
            r = (TW+18)'(-16384);
        end
        return 16'(r);
    endfunction

    // Stage A: pairwise products; s2 and s3 pass through.
    logic signed [TW+1:0] a_c1c3, a_s1s2, a_c2s3, a_c1s2, a_c3s1, a_c1s3, a_c2c3;
    logic signed [TW+1:0] a_s1s3, a_c2s1, a_c1c2, a_s2, a_s3;
    // Stage B: triple products and sums, or copies of stage A terms.
    logic signed [TW+2:0] b_e [0:8];
    // Stage C: Q2.14 entries.
    logic signed [15:0] c_e [0:8];
    // Stage D: partial dot products, E: sum, F: output.
    logic signed [48:0] d_p [0:8];
    logic signed [15:0] d_e [0:8];
    logic signed [51:0] e_s [0:2];
    logic signed [15:0] e_e [0:8];
    logic [OUT_DATA_W-1:0] out_reg;

    function automatic logic [31:0] fin_t(input logic signed [51:0] d);
        logic signed [52:0] t;
        t = (-(53'(d)) + 53'sd8192) >>> 14;
        if (t > 53'sd2147483647)
        begin
            t = 53'sd2147483647;
        end
        else if (t < -53'sd2147483648)
        begin
            t = -53'sd2147483648;
        end
        return 32'(t);
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg[0] <= s_axis_tdata[143:48];
            for (int i = 1; i < 9; i++)
            begin
                pos_reg[i] <= pos_reg[i-1];
            end
            a_c1c3 <= tm((TW+2)'(c1), (TW+2)'(c3));
            a_s1s2 <= tm((TW+2)'(s1), (TW+2)'(s2));
            a_c2s3 <= tm((TW+2)'(c2), (TW+2)'(s3));
            a_c1s2 <= tm((TW+2)'(c1), (TW+2)'(s2));
            a_c3s1 <= tm((TW+2)'(c3), (TW+2)'(s1));
            a_c1s3 <= tm((TW+2)'(c1), (TW+2)'(s3));
            a_c2c3 <= tm((TW+2)'(c2), (TW+2)'(c3));
            a_s1s3 <= tm((TW+2)'(s1), (TW+2)'(s3));
            a_c2s1 <= tm((TW+2)'(c2), (TW+2)'(s1));
            a_c1c2 <= tm((TW+2)'(c1), (TW+2)'(c2));
            a_s2   <= (TW+2)'(s2);
            a_s3   <= (TW+2)'(s3);

            b_e[0] <= (TW+3)'(a_c1c3) + (TW+3)'(tm(a_s1s2, a_s3));
            b_e[1] <= (TW+3)'(a_c2s3);
            b_e[2] <= (TW+3)'(tm(a_c1s2, a_s3)) - (TW+3)'(a_c3s1);
            b_e[3] <= (TW+3)'(tm(a_c3s1, a_s2)) - (TW+3)'(a_c1s3);
            b_e[4] <= (TW+3)'(a_c2c3);
            b_e[5] <= (TW+3)'(tm(a_c1c3, a_s2)) + (TW+3)'(a_s1s3);
            b_e[6] <= (TW+3)'(a_c2s1);
            b_e[7] <= -(TW+3)'(a_s2);
            b_e[8] <= (TW+3)'(a_c1c2);

            for (int i = 0; i < 9; i++)
            begin
                c_e[i] <= to14(b_e[i]);
                d_e[i] <= c_e[i];
                e_e[i] <= d_e[i];
            end

            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    d_p[3*r+k] <= 49'(c_e[3*r+k]) * 49'($signed(pos_reg[8][32*k +: 32]));
                end
                e_s[r] <= 52'(d_p[3*r]) + 52'(d_p[3*r+1]) + 52'(d_p[3*r+2]);
            end

            for (int i = 0; i < 9; i++)
            begin
                out_reg[16*i +: 16] <= e_e[i];
            end
            for (int r = 0; r < 3; r++)
            begin
                out_reg[144 + 32*r +: 32] <= fin_t(e_s[r]);
            end
        end
    end

    assign m_axis_tdata = out_reg;

endmodule

@@ hdl/eyxz_checker.sv @@
module eyxz_checker
    import eyxz_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed during stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked while output drains");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input blocked without a stalled output");

endmodule

bind euler_yxz_view_matrix_top eyxz_checker u_eyxz_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
